### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### hw/rtl/umoa_pkg.sv
// ---------------------------------------------------------------------------
// umoa_pkg
// Types and constants of the ultrasonic median obstacle alert.
// ---------------------------------------------------------------------------
`default_nettype none

package umoa_pkg;

	localparam int ECHO_W      = 16;
	localparam int DIST_W      = 16;
	localparam int THR_W       = 8;
	localparam int MULT_W      = 13;
	localparam int PROD_W      = ECHO_W + MULT_W;
	localparam int DIST_SHIFT  = 10;
	localparam int DIST_RAW_W  = PROD_W - DIST_SHIFT;
	localparam int CFG_IDX_W   = 2;

	localparam logic [ECHO_W-1:0]     ECHO_TIMEOUT_US = 16'd20000;
	localparam logic [MULT_W-1:0]     DIST_MULT       = 13'd4496;
	localparam logic [DIST_RAW_W-1:0] DIST_MIN        = 19'd512;
	localparam logic [DIST_RAW_W-1:0] DIST_MAX        = 19'd64000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOP_THR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRONT_THR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_THR = 2'd2;

	localparam logic [THR_W-1:0] TOP_THR_RST    = 8'd80;
	localparam logic [THR_W-1:0] FRONT_THR_RST  = 8'd100;
	localparam logic [THR_W-1:0] BOTTOM_THR_RST = 8'd70;

	typedef struct packed {
		logic [ECHO_W-1:0] top_echo_first;
		logic [ECHO_W-1:0] top_echo_second;
		logic [ECHO_W-1:0] top_echo_third;
		logic [ECHO_W-1:0] front_echo_first;
		logic [ECHO_W-1:0] front_echo_second;
		logic [ECHO_W-1:0] front_echo_third;
		logic [ECHO_W-1:0] bottom_echo_first;
		logic [ECHO_W-1:0] bottom_echo_second;
		logic [ECHO_W-1:0] bottom_echo_third;
	} in_t;

	typedef struct packed {
		logic [DIST_W-1:0] top_distance;
		logic              top_valid;
		logic [DIST_W-1:0] front_distance;
		logic              front_valid;
		logic [DIST_W-1:0] bottom_distance;
		logic              bottom_valid;
		logic              top_alert;
		logic              front_alert;
		logic              bottom_alert;
		logic              left_motor_on;
		logic              right_motor_on;
	} out_t;

	// three echoes of one sensor
	typedef struct packed {
		logic [ECHO_W-1:0] first;
		logic [ECHO_W-1:0] second;
		logic [ECHO_W-1:0] third;
	} sensor_echo_t;

	// what one lane found for its sensor
	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              valid;
		logic              alert;
	} lane_res_t;

endpackage

`default_nettype wire

### hw/rtl/ultrasonic_median_obstacle_alert.sv
// ---------------------------------------------------------------------------
// ultrasonic_median_obstacle_alert
// Path: an accepted input word is registered as lane keys in s1, then as the output word in s2.
// Throughput: one word per cycle while out_ready is high; set by the two-stage lane pipeline.
// Reset (arst_n low, asynchronous): pipeline empty, thresholds 80/100/70 cm.
// ---------------------------------------------------------------------------
`default_nettype none

module ultrasonic_median_obstacle_alert (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  umoa_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output umoa_pkg::out_t                    out_data,
	input  logic                              cfg_write,
	input  logic [umoa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [umoa_pkg::THR_W-1:0]        cfg_data
);

	// Pipeline:
	//   s1 - each lane turns its three echoes into ranking keys
	//        (constant multiply, shift, range checks) and registers them.
	//   s2 - each lane takes the median of its keys and compares against
	//        its threshold; the merge stage ORs alerts into the motor bits
	//        and registers the output word.
	// A stage advances when it is empty or its successor advances, so a
	// stalled output word still lets an empty s1 take the next word.

	logic [umoa_pkg::THR_W-1:0] top_thr_q, front_thr_q, bottom_thr_q;
	logic                       vld_s1, vld_s2;
	logic                       load_s1, load_s2;
	umoa_pkg::lane_res_t        top_res, front_res, bottom_res;
	umoa_pkg::sensor_echo_t     top_echoes, front_echoes, bottom_echoes;

	assign load_s2  = !vld_s2 || out_ready;
	assign load_s1  = !vld_s1 || load_s2;
	assign in_ready = load_s1;
	assign out_valid = vld_s2;

	// threshold registers; unknown index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_thr_q    <= umoa_pkg::TOP_THR_RST;
			front_thr_q  <= umoa_pkg::FRONT_THR_RST;
			bottom_thr_q <= umoa_pkg::BOTTOM_THR_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				umoa_pkg::REG_TOP_THR:    top_thr_q    <= cfg_data;
				umoa_pkg::REG_FRONT_THR:  front_thr_q  <= cfg_data;
				umoa_pkg::REG_BOTTOM_THR: bottom_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				vld_s1 <= in_valid;
			end
			if (load_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	assign top_echoes    = '{first:  in_data.top_echo_first,
	                         second: in_data.top_echo_second,
	                         third:  in_data.top_echo_third};
	assign front_echoes  = '{first:  in_data.front_echo_first,
	                         second: in_data.front_echo_second,
	                         third:  in_data.front_echo_third};
	assign bottom_echoes = '{first:  in_data.bottom_echo_first,
	                         second: in_data.bottom_echo_second,
	                         third:  in_data.bottom_echo_third};

	// one lane per sensor
	umoa_lane u_lane_top (
		.clk       (clk),
		.load_s1   (load_s1),
		.echoes    (top_echoes),
		.threshold (top_thr_q),
		.res       (top_res)
	);

	umoa_lane u_lane_front (
		.clk       (clk),
		.load_s1   (load_s1),
		.echoes    (front_echoes),
		.threshold (front_thr_q),
		.res       (front_res)
	);

	umoa_lane u_lane_bottom (
		.clk       (clk),
		.load_s1   (load_s1),
		.echoes    (bottom_echoes),
		.threshold (bottom_thr_q),
		.res       (bottom_res)
	);

	// merge lanes into the output word
	umoa_merge u_merge (
		.clk        (clk),
		.load_s2    (load_s2),
		.top_res    (top_res),
		.front_res  (front_res),
		.bottom_res (bottom_res),
		.data_s2    (out_data)
	);

endmodule

`default_nettype wire

### hw/rtl/umoa_lane.sv
// ---------------------------------------------------------------------------
// umoa_lane
// One sensor: echo to ranking key (registered), then median and alert.
// ---------------------------------------------------------------------------
`default_nettype none

module umoa_lane (
	input  logic                              clk,
	input  logic                              load_s1,
	input  umoa_pkg::sensor_echo_t            echoes,
	input  logic [umoa_pkg::THR_W-1:0]        threshold,
	output umoa_pkg::lane_res_t               res
);

	logic [umoa_pkg::ECHO_W-1:0]     echo [3];
	logic [umoa_pkg::PROD_W-1:0]     prod [3];
	logic [umoa_pkg::DIST_RAW_W-1:0] dist_raw [3];
	logic [umoa_pkg::DIST_W-1:0]     key [3];
	logic [umoa_pkg::DIST_W-1:0]     key_s1 [3];
	logic [umoa_pkg::DIST_W-1:0]     lo, hi, med;

	assign echo[0] = echoes.first;
	assign echo[1] = echoes.second;
	assign echo[2] = echoes.third;

	// key is 0 for no reading, distance + 1 otherwise
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i]     = umoa_pkg::PROD_W'(echo[i])
				* umoa_pkg::PROD_W'(umoa_pkg::DIST_MULT);
			dist_raw[i] = prod[i][umoa_pkg::PROD_W-1:umoa_pkg::DIST_SHIFT];
			if (echo[i] == '0 || echo[i] > umoa_pkg::ECHO_TIMEOUT_US
				|| dist_raw[i] < umoa_pkg::DIST_MIN
				|| dist_raw[i] > umoa_pkg::DIST_MAX) begin
				key[i] = '0;
			end else begin
				key[i] = dist_raw[i][umoa_pkg::DIST_W-1:0] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			key_s1 <= key;
		end
	end

	always_comb begin
		lo  = (key_s1[0] < key_s1[1]) ? key_s1[0] : key_s1[1];
		hi  = (key_s1[0] < key_s1[1]) ? key_s1[1] : key_s1[0];
		if (key_s1[2] <= lo) begin
			med = lo;
		end else if (key_s1[2] >= hi) begin
			med = hi;
		end else begin
			med = key_s1[2];
		end
		res.valid    = (med != '0);
		res.distance = res.valid ? (med - 1'b1) : '0;
		// d < thr*256 is the same as d/256 < thr
		res.alert    = res.valid && (res.distance[umoa_pkg::DIST_W-1:8] < threshold);
	end

endmodule

`default_nettype wire

### hw/rtl/umoa_merge.sv
// ---------------------------------------------------------------------------
// umoa_merge
// Combines the three lane results, derives motors, holds the output word.
// ---------------------------------------------------------------------------
`default_nettype none

module umoa_merge (
	input  logic                clk,
	input  logic                load_s2,
	input  umoa_pkg::lane_res_t top_res,
	input  umoa_pkg::lane_res_t front_res,
	input  umoa_pkg::lane_res_t bottom_res,
	output umoa_pkg::out_t      data_s2
);

	always_ff @(posedge clk) begin
		if (load_s2) begin
			data_s2.top_distance    <= top_res.distance;
			data_s2.top_valid       <= top_res.valid;
			data_s2.front_distance  <= front_res.distance;
			data_s2.front_valid     <= front_res.valid;
			data_s2.bottom_distance <= bottom_res.distance;
			data_s2.bottom_valid    <= bottom_res.valid;
			data_s2.top_alert       <= top_res.alert;
			data_s2.front_alert     <= front_res.alert;
			data_s2.bottom_alert    <= bottom_res.alert;
			data_s2.left_motor_on   <= top_res.alert | front_res.alert;
			data_s2.right_motor_on  <= front_res.alert | bottom_res.alert;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/umoa_checker.sv
// ---------------------------------------------------------------------------
// umoa_checker
// Port-level checks on the obstacle alert output words.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module umoa_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input umoa_pkg::out_t out_data
);

	`ASSERT_IMPL(a_left_motor, clk, arst_n, out_valid, out_data.left_motor_on == (out_data.top_alert || out_data.front_alert))
	`ASSERT_IMPL(a_right_motor, clk, arst_n, out_valid, out_data.right_motor_on == (out_data.front_alert || out_data.bottom_alert))
	`ASSERT_IMPL(a_alert_needs_valid, clk, arst_n, out_valid, (!out_data.top_alert || out_data.top_valid) && (!out_data.front_alert || out_data.front_valid) && (!out_data.bottom_alert || out_data.bottom_valid))
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind ultrasonic_median_obstacle_alert umoa_checker u_umoa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

### tb/sv/umoa_alert_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// umoa_alert_checker
// Watches the input, output and threshold ports of the obstacle alert,
// predicts the result word of every accepted echo word and compares the
// results in order.
// ---------------------------------------------------------------------------

module umoa_alert_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  umoa_pkg::in_t                  in_data,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  umoa_pkg::out_t                 out_data,
	input  logic                           cfg_write,
	input  logic [umoa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [umoa_pkg::THR_W-1:0]     cfg_data,
	output int                             pending,
	output int                             mismatches
);

	localparam int NO_ECHO_AFTER_US = 20000;
	localparam int CM_PER_US_Q10    = 4496;	// 0.0343/2 cm per us, 1/256 cm, Q10
	localparam int Q10_SHIFT        = 10;
	localparam int NEAREST_Q8       = 512;	// 2 cm
	localparam int FARTHEST_Q8      = 64000;	// 250 cm

	localparam logic [7:0] TOP_CM_AT_RESET    = 8'd80;
	localparam logic [7:0] FRONT_CM_AT_RESET  = 8'd100;
	localparam logic [7:0] BOTTOM_CM_AT_RESET = 8'd70;

	logic [7:0]     top_cm, front_cm, bottom_cm;
	umoa_pkg::out_t expected_alerts[$];
	umoa_pkg::out_t want;

	// 0 for an unusable echo, else distance + 1, so bad readings sort lowest
	function automatic logic [16:0] echo_rank(input logic [15:0] echo);
		logic [31:0] dist_q8;
		dist_q8 = (32'(echo) * CM_PER_US_Q10) >> Q10_SHIFT;
		if (echo == 16'd0 || echo > NO_ECHO_AFTER_US || dist_q8 < NEAREST_Q8 ||
				dist_q8 > FARTHEST_Q8)
			return '0;
		return 17'(dist_q8 + 1);
	endfunction

	function automatic umoa_pkg::lane_res_t judge_sensor(input umoa_pkg::sensor_echo_t e,
			input logic [7:0] cm);
		logic [16:0]         a, b, c, lo, hi, mid;
		umoa_pkg::lane_res_t r;
		a  = echo_rank(e.first);
		b  = echo_rank(e.second);
		c  = echo_rank(e.third);
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c <= lo)
			mid = lo;
		else if (c >= hi)
			mid = hi;
		else
			mid = c;
		r = '0;
		if (mid != '0) begin
			r.distance = 16'(mid - 17'd1);
			r.valid    = 1'b1;
			r.alert    = 32'(mid - 17'd1) < 32'(cm) * 256;
		end
		return r;
	endfunction

	function automatic umoa_pkg::out_t predict_alerts(input umoa_pkg::in_t w);
		umoa_pkg::sensor_echo_t t, f, b;
		umoa_pkg::lane_res_t    tr, fr, br;
		umoa_pkg::out_t         o;
		t.first  = w.top_echo_first;
		t.second = w.top_echo_second;
		t.third  = w.top_echo_third;
		f.first  = w.front_echo_first;
		f.second = w.front_echo_second;
		f.third  = w.front_echo_third;
		b.first  = w.bottom_echo_first;
		b.second = w.bottom_echo_second;
		b.third  = w.bottom_echo_third;
		tr = judge_sensor(t, top_cm);
		fr = judge_sensor(f, front_cm);
		br = judge_sensor(b, bottom_cm);
		o.top_distance    = tr.distance;
		o.top_valid       = tr.valid;
		o.front_distance  = fr.distance;
		o.front_valid     = fr.valid;
		o.bottom_distance = br.distance;
		o.bottom_valid    = br.valid;
		o.top_alert       = tr.alert;
		o.front_alert     = fr.alert;
		o.bottom_alert    = br.alert;
		o.left_motor_on   = tr.alert | fr.alert;
		o.right_motor_on  = fr.alert | br.alert;
		return o;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_cm    = TOP_CM_AT_RESET;
			front_cm  = FRONT_CM_AT_RESET;
			bottom_cm = BOTTOM_CM_AT_RESET;
			expected_alerts.delete();
			mismatches = 0;
			pending   <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					umoa_pkg::REG_TOP_THR:    top_cm    = cfg_data;
					umoa_pkg::REG_FRONT_THR:  front_cm  = cfg_data;
					umoa_pkg::REG_BOTTOM_THR: bottom_cm = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_alerts.push_back(predict_alerts(in_data));
			if (out_valid && out_ready) begin
				if (expected_alerts.size() == 0) begin
					$display("%0t: result word expected none, got %h", $time, out_data);
					mismatches++;
				end else begin
					want = expected_alerts.pop_front();
					check_field("top_distance", want.top_distance, out_data.top_distance);
					check_field("top_valid", want.top_valid, out_data.top_valid);
					check_field("front_distance", want.front_distance,
						out_data.front_distance);
					check_field("front_valid", want.front_valid, out_data.front_valid);
					check_field("bottom_distance", want.bottom_distance,
						out_data.bottom_distance);
					check_field("bottom_valid", want.bottom_valid, out_data.bottom_valid);
					check_field("top_alert", want.top_alert, out_data.top_alert);
					check_field("front_alert", want.front_alert, out_data.front_alert);
					check_field("bottom_alert", want.bottom_alert, out_data.bottom_alert);
					check_field("left_motor_on", want.left_motor_on, out_data.left_motor_on);
					check_field("right_motor_on", want.right_motor_on,
						out_data.right_motor_on);
				end
			end
			pending <= expected_alerts.size();
		end
	end

endmodule

### tb/sv/ultrasonic_median_obstacle_alert_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ultrasonic_median_obstacle_alert_tb
// Drives echo words into the obstacle alert under several threshold
// settings and handshake pressures; the checker beside the block predicts
// and compares every result word, this module only decides the verdict.
// ---------------------------------------------------------------------------

module ultrasonic_median_obstacle_alert_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 12;
	localparam int WORDS_PER_PHASE = 96;
	localparam int SETTLE_CYCLES = 8;	// well over the pipeline latency

	// index with no register behind it, writes must be dropped
	localparam logic [umoa_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	umoa_pkg::in_t                  in_data;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	umoa_pkg::out_t                 out_data;
	logic                           cfg_write;
	logic [umoa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [umoa_pkg::THR_W-1:0]     cfg_data;

	int pending;
	int mismatches;
	int cycle_count = 0;

	// percent chance per cycle of a sender gap / receiver stall
	int gap_pct   = 0;
	int stall_pct = 0;

	// thresholds as last written, only used to aim echoes at the alert edge
	int thr_now[3] = '{80, 100, 70};

	ultrasonic_median_obstacle_alert dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	umoa_alert_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.mismatches (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver: stalls drawn afresh every cycle
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("ultrasonic_median_obstacle_alert test failed");
		$finish;
	end

	function automatic umoa_pkg::in_t frame(input logic [15:0] t0, t1, t2, f0, f1, f2,
			b0, b1, b2);
		umoa_pkg::in_t w;
		w.top_echo_first     = t0;
		w.top_echo_second    = t1;
		w.top_echo_third     = t2;
		w.front_echo_first   = f0;
		w.front_echo_second  = f1;
		w.front_echo_third   = f2;
		w.bottom_echo_first  = b0;
		w.bottom_echo_second = b1;
		w.bottom_echo_third  = b2;
		return w;
	endfunction

	// Echo mix: mostly in range, a good share aimed at the alert edge,
	// the rest silent, timed out, too near, too far or raw 16-bit noise.
	// Usable echoes run from 117 us (just over 2 cm) to 14576 us (250 cm).
	function automatic logic [15:0] pick_echo(input int cm);
		int pick, edge_us;
		pick    = $urandom_range(99);
		edge_us = cm * 262144 / 4496;
		if (pick < 10)
			return 16'($urandom);
		else if (pick < 15)
			return 16'd0;
		else if (pick < 20)
			return 16'($urandom_range(65535, 20001));
		else if (pick < 25)
			return 16'($urandom_range(116, 1));
		else if (pick < 30)
			return 16'($urandom_range(20000, 14577));
		else if (pick < 50) begin
			edge_us = edge_us + $urandom_range(6) - 3;
			return 16'((edge_us < 0) ? 0 : edge_us);
		end
		return 16'($urandom_range(14576, 117));
	endfunction

	// valid held with its word until taken; gaps only between words
	task automatic send_word(input umoa_pkg::in_t w);
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	// pending is registered, so wait a clock edge first so it covers the last word taken
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// the stray write to the unused index sits between real ones on purpose
	task automatic program_thresholds(input logic [7:0] t, f, b);
		cfg_write <= 1'b1;
		cfg_index <= umoa_pkg::REG_TOP_THR;
		cfg_data  <= t;
		@(posedge clk);
		cfg_index <= umoa_pkg::REG_FRONT_THR;
		cfg_data  <= f;
		@(posedge clk);
		cfg_index <= REG_UNUSED;
		cfg_data  <= 8'($urandom);
		@(posedge clk);
		cfg_index <= umoa_pkg::REG_BOTTOM_THR;
		cfg_data  <= b;
		@(posedge clk);
		cfg_write <= 1'b0;
		thr_now[0] = int'(t);
		thr_now[1] = int'(f);
		thr_now[2] = int'(b);
	endtask

	initial begin
		logic [7:0] t, f, b;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_write = 1'b0;
		cfg_index = umoa_pkg::REG_TOP_THR;
		cfg_data  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset thresholds (80 / 100 / 70 cm).
		// Silent sensors, then all ones
		send_word(frame(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF));
		// timeout edge: 20000 us is not a timeout but is far beyond 250 cm
		send_word(frame(20000, 20000, 20000, 20001, 20001, 20001, 0, 20000, 20001));
		// nearest and farthest usable echoes and the ones just outside
		send_word(frame(116, 116, 116, 117, 117, 117, 14576, 14576, 14576));
		send_word(frame(14577, 14577, 14577, 117, 14576, 14577, 116, 117, 14576));
		// two bad readings give a bad median; one bad gives the lower good one
		send_word(frame(117, 0, 0, 0, 3000, 65535, 116, 20001, 9000));
		send_word(frame(0, 3000, 1000, 1000, 65535, 3000, 3000, 1000, 116));
		// alert edge of each sensor: just under, then just over
		send_word(frame(4664, 4664, 4664, 5830, 5830, 5830, 4081, 4081, 4081));
		send_word(frame(4665, 4665, 4665, 5831, 5831, 5831, 4082, 4082, 4082));
		// one sensor alerting at a time: left only, both, right only
		send_word(frame(100, 1000, 2000, 9000, 9000, 9000, 9000, 9000, 9000));
		send_word(frame(9000, 9000, 9000, 100, 1000, 2000, 9000, 9000, 9000));
		send_word(frame(9000, 9000, 9000, 9000, 9000, 9000, 100, 1000, 2000));
		// median sitting in each position, and ties
		send_word(frame(1000, 2000, 3000, 3000, 1000, 2000, 2000, 3000, 1000));
		send_word(frame(3000, 2000, 1000, 1000, 3000, 2000, 2000, 1000, 3000));
		send_word(frame(500, 500, 900, 900, 500, 500, 500, 900, 500));
		// alternating bit patterns, unusable echoes
		send_word(frame(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
			16'hAAAA, 16'h5555, 16'hAAAA));
		drain();

		// Random phases: a threshold setting and an idling pattern each.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin t = 8'd0;   f = 8'd0;   b = 8'd0;   end
				1: begin t = 8'd250; f = 8'd250; b = 8'd250; end
				2: begin t = 8'd255; f = 8'd255; b = 8'd255; end
				3: begin t = 8'd1;   f = 8'd128; b = 8'd249; end
				4: begin t = 8'd80;  f = 8'd100; b = 8'd70;  end
				default: begin
					t = 8'($urandom_range(255));
					f = 8'($urandom_range(255));
					b = 8'($urandom_range(255));
				end
			endcase
			program_thresholds(t, f, b);
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 83; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 83; end
				default: begin gap_pct = 13; stall_pct = 13; end
			endcase
			for (int n = 0; n < WORDS_PER_PHASE; n++)
				send_word(frame(pick_echo(thr_now[0]), pick_echo(thr_now[0]),
					pick_echo(thr_now[0]), pick_echo(thr_now[1]), pick_echo(thr_now[1]),
					pick_echo(thr_now[1]), pick_echo(thr_now[2]), pick_echo(thr_now[2]),
					pick_echo(thr_now[2])));
			drain();
		end

		// quiet spell to catch any word the block makes up on its own
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("ultrasonic_median_obstacle_alert test passed");
		else
			$display("ultrasonic_median_obstacle_alert test failed");
		$finish;
	end

endmodule
